// File: hw/rtl/vesm_pkg.sv
// Shared types and constants of the vision error steering mixer.
// No dependencies; imported by every module of the block.
`default_nettype none

package vesm_pkg;

    localparam int BYTE_W   = 8;
    localparam int CENTER_W = 10;
    localparam int SPEED_W  = 16;
    localparam int BAND_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes of the write port
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_REF       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE_ERROR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTERED_SPEED   = 3'd5;

    // reset values
    localparam logic [CENTER_W-1:0] RST_CENTER_REF       = 10'd350;
    localparam logic [SPEED_W-1:0]  RST_MAX_SPEED        = 16'd800;
    localparam logic [SPEED_W-1:0]  RST_MIN_SPEED        = 16'd500;
    localparam logic [BAND_W-1:0]   RST_DEAD_BAND        = 8'd30;
    localparam logic [SPEED_W-1:0]  RST_FULL_SCALE_ERROR = 16'd200;
    localparam logic [SPEED_W-1:0]  RST_CENTERED_SPEED   = 16'd550;

    // characters
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'd9;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'd43;
    localparam logic [BYTE_W-1:0] CH_MINUS   = 8'd45;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'd48;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'd57;

    // line queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CENTER_W-1:0] center_ref;
        logic [SPEED_W-1:0]  max_speed;
        logic [SPEED_W-1:0]  min_speed;
        logic [BAND_W-1:0]   dead_band;
        logic [SPEED_W-1:0]  full_scale_error;
        logic [SPEED_W-1:0]  centered_speed;
    } cfg_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

    typedef enum logic [3:0] {
        PH_SKIP   = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_END    = 4'b1000
    } phase_t;

    typedef enum logic [4:0] {
        BK_IDLE  = 5'b00001,
        BK_MUL   = 5'b00010,
        BK_DIV   = 5'b00100,
        BK_CLAMP = 5'b01000,
        BK_DONE  = 5'b10000
    } back_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/vesm_front.sv
// Front end: parses received characters into a signed line value.
// Depends on vesm_pkg; pushes one entry per line end into vesm_queue.
`default_nettype none

module vesm_front #(
    parameter int LINE_CHARS = 3,
    parameter int DIGIT_W    = 10
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          byte_take,
    input  wire logic [vesm_pkg::BYTE_W-1:0]   rx_byte,
    output logic                               push,
    output logic [DIGIT_W:0]                   push_data   // {negative, digits}
);
    import vesm_pkg::*;

    localparam int CNT_W = $clog2(LINE_CHARS + 1);

    logic [CNT_W-1:0]   char_count_reg, char_count_next;
    phase_t             phase_reg, phase_next;
    logic               negative_reg, negative_next;
    logic [DIGIT_W-1:0] digit_reg, digit_next;

    logic               line_end;
    logic               is_space;
    logic               is_digit;
    logic [DIGIT_W+3:0] digit_acc;

    assign line_end  = (rx_byte == CH_NEWLINE) ||
                       (char_count_reg == CNT_W'(LINE_CHARS));
    assign is_space  = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
    assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign digit_acc = (DIGIT_W+4)'(digit_reg) * (DIGIT_W+4)'(10)
                     + (DIGIT_W+4)'(rx_byte - CH_ZERO);

    assign push      = byte_take && line_end;
    assign push_data = {negative_reg, digit_reg};

    always_comb begin
        char_count_next = char_count_reg;
        phase_next      = phase_reg;
        negative_next   = negative_reg;
        digit_next      = digit_reg;
        if (byte_take) begin
            if (line_end) begin
                char_count_next = '0;
                phase_next      = PH_SKIP;
                negative_next   = 1'b0;
                digit_next      = '0;
            end else begin
                char_count_next = char_count_reg + CNT_W'(1);
                if (phase_reg != PH_END) begin
                    if (is_digit) begin
                        digit_next = digit_acc[DIGIT_W-1:0];
                        phase_next = PH_DIGITS;
                    end else if ((phase_reg == PH_SKIP) && is_space) begin
                        phase_next = PH_SKIP;
                    end else if ((phase_reg == PH_SKIP) &&
                                 ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS))) begin
                        negative_next = (rx_byte == CH_MINUS);
                        phase_next    = PH_SIGN;
                    end else begin
                        phase_next = PH_END;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_count_reg <= '0;
            phase_reg      <= PH_SKIP;
            negative_reg   <= 1'b0;
            digit_reg      <= '0;
        end else begin
            char_count_reg <= char_count_next;
            phase_reg      <= phase_next;
            negative_reg   <= negative_next;
            digit_reg      <= digit_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/vesm_queue.sv
// Short line queue between the parser and the steering back end.
// Depends on vesm_pkg for depth and status type.
`default_nettype none

module vesm_queue #(
    parameter int WIDTH = 11
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire logic [WIDTH-1:0]        push_data,
    input  wire logic                    pop,
    output logic [WIDTH-1:0]             pop_data,
    output vesm_pkg::queue_status_t      status
);
    import vesm_pkg::*;

    logic [WIDTH-1:0]  mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign pop_data      = mem[rd_ptr_reg];
    assign status.count  = count_reg;
    assign status.full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty  = (count_reg == '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/vesm_back.sv
// Back end: error, dead band, multiply and bit-serial divide, output register.
// Depends on vesm_pkg; pops line values from vesm_queue.
`default_nettype none

module vesm_back #(
    parameter int LINE_CHARS = 3,
    parameter int DIGIT_W    = 10
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire vesm_pkg::cfg_t                     cfg,
    input  wire logic                               line_avail,
    input  wire logic [DIGIT_W:0]                   line_data,
    output logic                                    pop,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [2*vesm_pkg::SPEED_W-1:0]          m_tdata
);
    import vesm_pkg::*;

    localparam int MAG_W  = $clog2(10**LINE_CHARS + 2**CENTER_W - 1);
    localparam int ERR_W  = MAG_W + 1;
    localparam int PROD_W = SPEED_W + MAG_W;
    localparam int CNT_W  = $clog2(PROD_W + 1);

    back_state_t        state_reg, state_next;
    logic               valid_reg, valid_next;
    logic [2*SPEED_W-1:0] data_reg, data_next;
    logic               neg_err_reg, neg_err_next;
    logic               centre_reg, centre_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [SPEED_W-1:0] range_reg, range_next;
    logic [SPEED_W-1:0] adj_reg, adj_next;
    logic [PROD_W-1:0]  quo_reg, quo_next;
    logic [SPEED_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               line_neg;
    logic [DIGIT_W-1:0] line_digits;
    logic signed [ERR_W-1:0] value_s;
    logic signed [ERR_W-1:0] err_s;
    logic [ERR_W-1:0]   err_abs;
    logic [SPEED_W-1:0] range_c;
    logic [SPEED_W:0]   rem_shift;
    logic               rem_ge;
    logic [SPEED_W-1:0] ch1, ch2;
    logic               out_free;

    assign line_neg    = line_data[DIGIT_W];
    assign line_digits = line_data[DIGIT_W-1:0];
    assign value_s     = line_neg ? -signed'(ERR_W'(line_digits)) : signed'(ERR_W'(line_digits));
    assign err_s       = value_s - signed'(ERR_W'(cfg.center_ref));
    assign err_abs     = err_s[ERR_W-1] ? ERR_W'(-err_s) : ERR_W'(err_s);
    assign range_c     = (cfg.max_speed >= cfg.min_speed) ? cfg.max_speed - cfg.min_speed : '0;
    assign rem_shift   = {rem_reg, quo_reg[PROD_W-1]};
    assign rem_ge      = rem_shift >= {1'b0, cfg.full_scale_error};
    assign out_free    = !valid_reg || m_tready;

    assign pop      = (state_reg == BK_IDLE) && line_avail;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    always_comb begin
        if (centre_reg) begin
            ch1 = cfg.centered_speed;
            ch2 = cfg.centered_speed;
        end else if (neg_err_reg) begin
            ch1 = cfg.min_speed + adj_reg;
            ch2 = cfg.max_speed - adj_reg;
        end else begin
            ch1 = cfg.max_speed - adj_reg;
            ch2 = cfg.min_speed + adj_reg;
        end
    end

    always_comb begin
        state_next   = state_reg;
        valid_next   = valid_reg && !m_tready;
        data_next    = data_reg;
        neg_err_next = neg_err_reg;
        centre_next  = centre_reg;
        mag_next     = mag_reg;
        range_next   = range_reg;
        adj_next     = adj_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        case (state_reg)
            BK_IDLE: begin
                if (line_avail) begin
                    neg_err_next = err_s[ERR_W-1];
                    centre_next  = (err_s == '0) ||
                                   (!line_neg && (line_digits == DIGIT_W'(1)));
                    mag_next     = err_abs[MAG_W-1:0];
                    state_next   = BK_MUL;
                end
            end
            BK_MUL: begin
                range_next = range_c;
                quo_next   = PROD_W'(range_c) * PROD_W'(mag_reg);
                rem_next   = '0;
                cnt_next   = CNT_W'(PROD_W);
                if (centre_reg || (mag_reg <= MAG_W'(cfg.dead_band))) begin
                    adj_next   = '0;
                    state_next = BK_DONE;
                end else if (cfg.full_scale_error == '0) begin
                    adj_next   = range_c;
                    state_next = BK_DONE;
                end else begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                // restoring divide, one quotient bit per cycle
                rem_next = rem_ge ? SPEED_W'(rem_shift - {1'b0, cfg.full_scale_error})
                                  : rem_shift[SPEED_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], rem_ge};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = BK_CLAMP;
                end
            end
            BK_CLAMP: begin
                adj_next   = (quo_reg > PROD_W'(range_reg)) ? range_reg : quo_reg[SPEED_W-1:0];
                state_next = BK_DONE;
            end
            BK_DONE: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    data_next  = {ch2, ch1};
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg    <= data_next;
        neg_err_reg <= neg_err_next;
        centre_reg  <= centre_next;
        mag_reg     <= mag_next;
        range_reg   <= range_next;
        adj_reg     <= adj_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/vision_error_steering_mixer.sv
// Vision error steering mixer: serial line parser feeding a differential PWM mixer.
// A line-end transfer pushes the line value into the queue; the back end pops it only in
//   BK_IDLE, so it works on one line at a time, then runs BK_MUL, the bit-serial divide
//   in BK_DIV, BK_CLAMP and BK_DONE, which raises m_tvalid once the output is free; a
//   line without a divide (centred, in the dead band, zero full scale) skips to BK_DONE.
// Throughput: one character a cycle while the queue has room.
// Reset: aresetn, synchronous, active low; clears parser, queue, back end and
//   loads the default register values.
`default_nettype none

module vision_error_steering_mixer #(
    parameter int LINE_CHARS = 3
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration write port
    input  wire logic                               cfg_wr_en,
    input  wire logic [vesm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [vesm_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    // character stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // [7:0] rx_byte
    // compare value stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [31:0]                             m_tdata    // [15:0] ch1, [31:16] ch2
);
    import vesm_pkg::*;

    // digits of one line fit this width
    localparam int DIGIT_W = $clog2(10**LINE_CHARS);

    cfg_t          cfg_reg, cfg_next;
    queue_status_t q_status;
    logic          byte_take;
    logic          push;
    logic          pop;
    logic [DIGIT_W:0] push_data;
    logic [DIGIT_W:0] pop_data;

    // -------------------------------------------------------------------
    // Configuration registers; a write lands at once, so the user must see
    // that it is only issued while no line is in flight (not enforced).
    // -------------------------------------------------------------------
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_CENTER_REF:       cfg_next.center_ref       = cfg_wr_data[CENTER_W-1:0];
                REG_MAX_SPEED:        cfg_next.max_speed        = cfg_wr_data[SPEED_W-1:0];
                REG_MIN_SPEED:        cfg_next.min_speed        = cfg_wr_data[SPEED_W-1:0];
                REG_DEAD_BAND:        cfg_next.dead_band        = cfg_wr_data[BAND_W-1:0];
                REG_FULL_SCALE_ERROR: cfg_next.full_scale_error = cfg_wr_data[SPEED_W-1:0];
                REG_CENTERED_SPEED:   cfg_next.centered_speed   = cfg_wr_data[SPEED_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_ref       <= RST_CENTER_REF;
            cfg_reg.max_speed        <= RST_MAX_SPEED;
            cfg_reg.min_speed        <= RST_MIN_SPEED;
            cfg_reg.dead_band        <= RST_DEAD_BAND;
            cfg_reg.full_scale_error <= RST_FULL_SCALE_ERROR;
            cfg_reg.centered_speed   <= RST_CENTERED_SPEED;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // -------------------------------------------------------------------
    // Front end. Every byte is taken while the queue has room, so a
    // line-end transfer always finds a free slot.
    // -------------------------------------------------------------------
    assign s_tready  = !q_status.full;
    assign byte_take = s_tvalid && s_tready;

    vesm_front #(
        .LINE_CHARS (LINE_CHARS),
        .DIGIT_W    (DIGIT_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_take (byte_take),
        .rx_byte   (s_tdata),
        .push      (push),
        .push_data (push_data)
    );

    // line values wait here while the back end divides
    vesm_queue #(
        .WIDTH (DIGIT_W + 1)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    // -------------------------------------------------------------------
    // Back end: steering arithmetic and the output register.
    // -------------------------------------------------------------------
    vesm_back #(
        .LINE_CHARS (LINE_CHARS),
        .DIGIT_W    (DIGIT_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .line_avail (!q_status.empty),
        .line_data  (pop_data),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // -------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (q_status.count != '0))
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (q_status.count == $past(q_status.count) + QCNT_W'(1)))
        else $error("queue count missed a line");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && q_status.empty))
        else $error("output or queue busy after reset");

endmodule

`default_nettype wire

// File: dv/vesm_steer_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the vision error steering mixer: follows register writes and character
// transfers, predicts each compare pair and checks the compare stream in order.
// Depends on vesm_pkg.

module vesm_steer_checker
    import vesm_pkg::*;
#(
    parameter int LINE_CHARS = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [31:0]           m_tdata,   // [15:0] ch1, [31:16] ch2
    output int                    fail_count,
    output int                    pending,
    output int                    pair_count
);

    typedef struct packed {
        logic [SPEED_W-1:0] ch2;
        logic [SPEED_W-1:0] ch1;
    } pwm_pair_t;

    cfg_t        regs;
    int          line_len;
    phase_t      parse_state;
    logic        minus_taken;
    longint      digits_acc;
    pwm_pair_t   expected_pairs[$];

    initial begin
        fail_count = 0;
        pair_count = 0;
        pending    = 0;
    end

    function automatic pwm_pair_t steer_pair(longint value);
        longint    err;
        longint    mag;
        longint    span;
        longint    adj;
        pwm_pair_t pair;
        err = value - longint'(regs.center_ref);
        if (value == 1 || err == 0) begin
            pair.ch1 = regs.centered_speed;
            pair.ch2 = regs.centered_speed;
            return pair;
        end
        mag  = (err > 0) ? err : -err;
        span = (regs.max_speed >= regs.min_speed) ?
               longint'(regs.max_speed) - longint'(regs.min_speed) : 0;
        if (mag <= longint'(regs.dead_band)) begin
            adj = 0;
        end else if (regs.full_scale_error == '0) begin
            adj = span;
        end else begin
            adj = span * mag / longint'(regs.full_scale_error);
            if (adj > span) adj = span;
        end
        if (err > 0) begin
            pair.ch1 = 16'(longint'(regs.max_speed) - adj);
            pair.ch2 = 16'(longint'(regs.min_speed) + adj);
        end else begin
            pair.ch1 = 16'(longint'(regs.min_speed) + adj);
            pair.ch2 = 16'(longint'(regs.max_speed) - adj);
        end
        return pair;
    endfunction

    task automatic clear_line();
        line_len    = 0;
        parse_state = PH_SKIP;
        minus_taken = 1'b0;
        digits_acc  = 0;
    endtask

    // atoi-style parse of one stored character
    task automatic parse_char(logic [7:0] c);
        logic is_space;
        logic is_digit;
        is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        is_digit = (c >= CH_ZERO && c <= CH_NINE);
        if (parse_state == PH_END) begin
            // number already closed, rest of line ignored
        end else if (is_digit) begin
            digits_acc  = digits_acc * 10 + longint'(c - CH_ZERO);
            parse_state = PH_DIGITS;
        end else if (parse_state == PH_SKIP && is_space) begin
        end else if (parse_state == PH_SKIP && (c == CH_PLUS || c == CH_MINUS)) begin
            minus_taken = (c == CH_MINUS);
            parse_state = PH_SIGN;
        end else begin
            parse_state = PH_END;
        end
    endtask

    task automatic take_byte(logic [7:0] c);
        if (c != CH_NEWLINE && line_len < LINE_CHARS) begin
            parse_char(c);
            line_len++;
        end else begin
            // line end; an overflow byte is dropped
            expected_pairs.push_back(steer_pair(minus_taken ? -digits_acc : digits_acc));
            clear_line();
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_CENTER_REF:       regs.center_ref       = data[CENTER_W-1:0];
            REG_MAX_SPEED:        regs.max_speed        = data[SPEED_W-1:0];
            REG_MIN_SPEED:        regs.min_speed        = data[SPEED_W-1:0];
            REG_DEAD_BAND:        regs.dead_band        = data[BAND_W-1:0];
            REG_FULL_SCALE_ERROR: regs.full_scale_error = data[SPEED_W-1:0];
            REG_CENTERED_SPEED:   regs.centered_speed   = data[SPEED_W-1:0];
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin : watch
        pwm_pair_t got;
        pwm_pair_t want;
        if (!aresetn) begin
            regs.center_ref       = RST_CENTER_REF;
            regs.max_speed        = RST_MAX_SPEED;
            regs.min_speed        = RST_MIN_SPEED;
            regs.dead_band        = RST_DEAD_BAND;
            regs.full_scale_error = RST_FULL_SCALE_ERROR;
            regs.centered_speed   = RST_CENTERED_SPEED;
            clear_line();
            expected_pairs.delete();
        end else begin
            if (cfg_wr_en) write_reg(cfg_index, cfg_wr_data);
            if (s_tvalid && s_tready) take_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_pairs.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 40)
                        $display("%0t: unexpected compare pair: expected none, got ch1 %0d ch2 %0d",
                                 $time, got.ch1, got.ch2);
                end else begin
                    want = expected_pairs.pop_front();
                    pair_count++;
                    if (got.ch1 !== want.ch1) begin
                        fail_count++;
                        if (fail_count <= 40)
                            $display("%0t: ch1 mismatch: expected %0d, got %0d",
                                     $time, want.ch1, got.ch1);
                    end
                    if (got.ch2 !== want.ch2) begin
                        fail_count++;
                        if (fail_count <= 40)
                            $display("%0t: ch2 mismatch: expected %0d, got %0d",
                                     $time, want.ch2, got.ch2);
                    end
                end
            end
        end
        pending <= expected_pairs.size();
    end

endmodule

// File: dv/tb_vision_error_steering_mixer.sv
`timescale 1ns / 1ps
// Testbench top for the vision error steering mixer: clock, reset, character and register
// stimulus, output back-pressure and the verdict. Depends on vesm_pkg, the block and
// vesm_steer_checker.

module tb_vision_error_steering_mixer;
    import vesm_pkg::*;

    localparam int LINE_CHARS   = 3;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 64;    // pause after the last expected pair, before a register write
    localparam int HOLD_CYCLES  = 400;   // long output stall, enough to back up the input
    localparam int PHASE_ITEMS  = 50;    // least number of characters per register setting
    localparam logic [7:0] NUL_CHAR = 8'h00;
    localparam logic [7:0] TOP_CHAR = 8'hFF;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;     // [7:0] rx_byte
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;          // [15:0] ch1, [31:16] ch2

    int  fail_count;
    int  pending;
    int  pair_count;

    // stimulus bookkeeping: a copy of the settings only to aim lines near the centre
    bit              gaps_on = 1'b1;
    bit              hold_req = 1'b0;
    int              sent = 0;
    int              settings_count = 0;
    logic [CENTER_W-1:0] cur_center = RST_CENTER_REF;
    logic [BAND_W-1:0]   cur_band   = RST_DEAD_BAND;

    vision_error_steering_mixer #(
        .LINE_CHARS (LINE_CHARS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    vesm_steer_checker #(
        .LINE_CHARS (LINE_CHARS)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .pending     (pending),
        .pair_count  (pair_count)
    );

    // 8 ns clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    // single reset at the start of the run
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Hard limit: far above the slowest legal run (every byte a line end, every
    // pair waiting out a full stall, plus the long hold and the drain pauses).
    initial begin
        #5_000_000;
        $display("Timeout waiting for the compare stream");
        $display("** vision_error_steering_mixer: FAILED **");
        $finish;
    end

    // Result side: ready in random runs with random stall bursts, plus one long
    // hold-off on request. The hold is counted here, not in the stimulus.
    initial begin : receiver
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // One character transfer. tvalid is left high on return so that back-to-back
    // characters never lower and raise it in the same step.
    task automatic send_byte(logic [7:0] c);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    task automatic send_text(string body, logic [7:0] term);
        for (int i = 0; i < body.len(); i++) send_byte(body[i]);
        send_byte(term);
    endtask

    // Mostly well-formed lines with random content; some aimed at the dead band
    // edges and the command one, the rest noise.
    task automatic send_random_line();
        logic [7:0] seq[$];
        int         kind;
        int         v;
        int         nd;
        string      txt;
        logic [7:0] junk;
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                // raw noise, any byte value including newlines
                repeat ($urandom_range(1, 5)) seq.push_back(8'($urandom_range(0, 255)));
                seq.push_back(CH_NEWLINE);
            end
            1: begin
                // command one, possibly with a leading space or plus
                case ($urandom_range(0, 2))
                    0: seq.push_back(CH_SPACE);
                    1: seq.push_back(CH_PLUS);
                    default: ;
                endcase
                seq.push_back(CH_ZERO + 8'd1);
                seq.push_back(CH_NEWLINE);
            end
            2, 3: begin
                // around the centre, straddling the dead band limits
                v = int'(cur_center) + int'($urandom_range(0, 2 * int'(cur_band) + 6))
                    - (int'(cur_band) + 3);
                txt = $sformatf("%0d", v);
                for (int i = 0; i < txt.len() && i < LINE_CHARS; i++) seq.push_back(txt[i]);
                seq.push_back(CH_NEWLINE);
            end
            default: begin
                if ($urandom_range(0, 3) == 0)
                    seq.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4)));
                if ($urandom_range(0, 2) == 0)
                    seq.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
                nd = $urandom_range(0, LINE_CHARS - seq.size());
                repeat (nd) seq.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                // stray character that closes the number early
                if (seq.size() < LINE_CHARS && $urandom_range(0, 5) == 0)
                    seq.push_back(8'($urandom_range(0, 255)));
                // a full line may end on an overflow byte instead of a newline
                if (seq.size() >= LINE_CHARS && $urandom_range(0, 4) == 0) begin
                    junk = 8'($urandom_range(0, 255));
                    seq.push_back((junk == CH_NEWLINE) ? TOP_CHAR : junk);
                end else begin
                    seq.push_back(CH_NEWLINE);
                end
            end
        endcase
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    // Wait for every expected pair, then let the back end finish before a write.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes all six registers on consecutive edges; unused upper data bits are
    // filled at random to show they are ignored.
    task automatic load_settings(logic [CENTER_W-1:0] center, logic [SPEED_W-1:0] top_speed,
                                 logic [SPEED_W-1:0] low_speed, logic [BAND_W-1:0] band,
                                 logic [SPEED_W-1:0] scale, logic [SPEED_W-1:0] mid_speed);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_CENTER_REF;
        cfg_wr_data <= {6'($urandom_range(0, 63)), center};
        @(posedge aclk);
        cfg_index   <= REG_MAX_SPEED;
        cfg_wr_data <= top_speed;
        @(posedge aclk);
        cfg_index   <= REG_MIN_SPEED;
        cfg_wr_data <= low_speed;
        @(posedge aclk);
        cfg_index   <= REG_DEAD_BAND;
        cfg_wr_data <= {8'($urandom_range(0, 255)), band};
        @(posedge aclk);
        cfg_index   <= REG_FULL_SCALE_ERROR;
        cfg_wr_data <= scale;
        @(posedge aclk);
        cfg_index   <= REG_CENTERED_SPEED;
        cfg_wr_data <= mid_speed;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_center  = center;
        cur_band    = band;
        settings_count++;
    endtask

    task automatic run_phase(logic [CENTER_W-1:0] center, logic [SPEED_W-1:0] top_speed,
                             logic [SPEED_W-1:0] low_speed, logic [BAND_W-1:0] band,
                             logic [SPEED_W-1:0] scale, logic [SPEED_W-1:0] mid_speed,
                             bit long_hold);
        int start;
        wait_idle();
        load_settings(center, top_speed, low_speed, band, scale, mid_speed);
        if (long_hold) hold_req = 1'b1;
        start = sent;
        while (sent - start < PHASE_ITEMS) send_random_line();
        // close any open line so nothing straddles a register change
        send_byte(CH_NEWLINE);
    endtask

    initial begin : stimulus
        logic [SPEED_W-1:0] hi;
        logic [SPEED_W-1:0] lo;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        @(posedge aclk);

        // directed lines at the reset settings
        send_text("1", CH_NEWLINE);          // command one: centred on both channels
        send_byte(CH_NEWLINE);               // empty line: value zero
        send_text(" -5", CH_NEWLINE);        // whitespace then sign
        send_text("+", CH_NEWLINE);          // sign with no digits
        send_text("999", CH_PLUS);           // overflow byte ends and is dropped; clamped
        send_byte(CH_ZERO + 8'd3);           // NUL inside the number stops it
        send_byte(NUL_CHAR);
        send_byte(CH_ZERO + 8'd5);
        send_byte(CH_NEWLINE);
        send_byte(CH_TAB);                   // tab skipped, top-bit byte as overflow
        send_text("12", TOP_CHAR);
        send_text("350", CH_NEWLINE);        // zero error at the reset centre

        // reset values written back explicitly, with the long output hold
        run_phase(RST_CENTER_REF, RST_MAX_SPEED, RST_MIN_SPEED, RST_DEAD_BAND,
                  RST_FULL_SCALE_ERROR, RST_CENTERED_SPEED, 1'b1);
        // extremes: zero centre, full speed span, no dead band, unit full scale
        run_phase(10'd0, 16'hFFFF, 16'h0000, 8'd0, 16'd1, 16'h0000, 1'b0);
        // extremes: top centre, no span, widest band, largest full scale
        run_phase(10'd1023, 16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF, 16'hFFFF, 1'b0);
        // speeds reversed: span taken as zero
        run_phase(10'd500, 16'd100, 16'd900, 8'd10, 16'd300, 16'd1234, 1'b0);
        // zero full scale: any error beyond the band gives the whole span
        run_phase(10'd200, 16'd3000, 16'd1000, 8'd5, 16'd0, 16'd2000, 1'b0);

        // random settings; the last set runs without any idling
        for (int k = 0; k < 3; k++) begin
            if (k == 2) gaps_on = 1'b0;
            hi = 16'($urandom_range(0, 65535));
            lo = 16'($urandom_range(0, int'(hi)));
            run_phase(10'($urandom_range(0, 1023)), hi, lo, 8'($urandom_range(0, 255)),
                      16'($urandom_range(1, 1000)), 16'($urandom_range(0, 65535)), 1'b0);
        end

        wait_idle();
        $display("Sent %0d characters over %0d register settings (with a %0d-cycle output hold);",
                 sent, settings_count, HOLD_CYCLES);
        $display("checked %0d compare pairs, %0d mismatches.", pair_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("** vision_error_steering_mixer: PASSED **");
        end else begin
            $display("** vision_error_steering_mixer: FAILED **");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/vesm_pkg.sv
hw/rtl/vesm_front.sv
hw/rtl/vesm_queue.sv
hw/rtl/vesm_back.sv
hw/rtl/vision_error_steering_mixer.sv
dv/vesm_steer_checker.sv
dv/tb_vision_error_steering_mixer.sv
